// File: design/srgd_pkg.sv
// Shared types and constants for the sparse row gather dot product block.
// Holds item kind codes, back-end op codes, the queue entry type and
// IEEE binary64 constants. No dependencies.
package srgd_pkg;

	localparam int VECTOR_DEPTH   = 4096;
	localparam int MAX_ROW_LENGTH = 65535;
	localparam int LANES          = 4;
	localparam int QDEPTH         = 4;
	localparam int QPTR_W         = 2;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_ELEM  = 2'd2;

	localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] NEG_ZERO    = 64'h8000_0000_0000_0000;
	localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
	localparam logic [62:0] INF_ABS     = 63'h7FF0_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_EMPTY = 2'd1,
		OP_LANE  = 2'd2,
		OP_TAIL  = 2'd3
	} op_code_t;

	typedef struct packed {
		op_code_t    op;
		logic [1:0]  lane;
		logic        combine;
		logic        last;
		logic [63:0] val;
		logic [63:0] x;
	} op_t;

	typedef struct packed {
		logic [QPTR_W:0] count;
		logic            empty;
	} fifo_stat_t;

endpackage

// File: design/srgd_front.sv
// Front end: takes items, keeps the dense vector memory and row bookkeeping,
// and turns each row event into a back-end op with its gathered entry.
// Depends on srgd_pkg.
module srgd_front import srgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [11:0] position,
	input  logic [63:0] value,
	input  logic [15:0] row_length,
	output logic        push,
	output op_t         push_data,
	input  fifo_stat_t  q_stat
);

	localparam logic [15:0] MAX_LEN   = 16'(MAX_ROW_LENGTH);
	localparam logic [15:0] LANE_MASK = 16'(LANES - 1);

	logic [63:0] vec_mem [VECTOR_DEPTH];
	logic [63:0] x_s2;
	logic        range_s2;
	op_t         op_s2;
	logic        valid_s2;
	logic [15:0] row_total_q;
	logic [15:0] seen_q;
	logic        row_open_q;

	logic        accept;
	logic        in_range;
	logic [15:0] len_sat;
	logic [15:0] full_cnt;
	logic [15:0] nxt;
	logic        in_lane;
	logic        go_n;
	op_t         op_n;

	// keep room in the queue for the item sitting in stage 2
	assign in_stall = ({1'b0, q_stat.count} + {{(QPTR_W + 1){1'b0}}, valid_s2})
		>= (QPTR_W + 2)'(QDEPTH);
	assign accept   = in_valid && !in_stall;
	assign in_range = 32'(position) < VECTOR_DEPTH;

	always_comb begin
		len_sat  = (row_length > MAX_LEN) ? MAX_LEN : row_length;
		full_cnt = row_total_q & ~LANE_MASK;
		nxt      = seen_q + 16'd1;
		in_lane  = seen_q < full_cnt;
		go_n     = 1'b0;
		op_n     = '0;
		op_n.val = value;
		if (accept) begin
			unique case (kind)
				KIND_START: begin
					go_n    = 1'b1;
					op_n.op = (len_sat == 16'd0) ? OP_EMPTY : OP_START;
				end
				KIND_ELEM: begin
					go_n         = row_open_q;
					op_n.op      = in_lane ? OP_LANE : OP_TAIL;
					op_n.lane    = seen_q[1:0];
					op_n.combine = in_lane && (nxt == full_cnt);
					op_n.last    = nxt >= row_total_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			row_total_q <= '0;
			seen_q      <= '0;
			row_open_q  <= 1'b0;
		end else begin
			valid_s2 <= go_n;
			if (accept && kind == KIND_START) begin
				row_total_q <= len_sat;
				seen_q      <= '0;
				row_open_q  <= len_sat != 16'd0;
			end else if (go_n && kind == KIND_ELEM) begin
				seen_q <= nxt;
				if (nxt >= row_total_q) begin
					row_open_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && kind == KIND_WRITE && in_range) begin
			vec_mem[position] <= value;
		end
		x_s2 <= vec_mem[position];
		if (go_n) begin
			op_s2    <= op_n;
			range_s2 <= in_range;
		end
	end

	assign push = valid_s2;

	always_comb begin
		push_data   = op_s2;
		push_data.x = range_s2 ? x_s2 : 64'd0;
	end

endmodule

// File: design/srgd_queue.sv
// Short op queue between the front end and the back end.
// Depends on srgd_pkg; the front end never pushes into a full queue.
module srgd_queue import srgd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  op_t        push_data,
	input  logic       pop,
	output op_t        head,
	output fifo_stat_t stat
);

	op_t               q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_data;
		end
	end

	assign head       = q_mem[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.empty = count_q == '0;

endmodule

// File: design/srgd_fma.sv
// Iterative binary64 fused multiply-add, round to nearest even.
// One 27x27 multiplier forms four partial products, then normalize, align, add,
// renormalize and round. Depends on srgd_pkg.
module srgd_fma import srgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	input  logic [63:0] op_c,
	output logic        done,
	output logic [63:0] result
);

	localparam logic signed [13:0] EMIN = -14'sd1022;

	typedef enum logic [6:0] {
		F_IDLE  = 7'b0000001,
		F_MUL   = 7'b0000010,
		F_NORM  = 7'b0000100,
		F_ALIGN = 7'b0001000,
		F_ADD   = 7'b0010000,
		F_FIX   = 7'b0100000,
		F_ROUND = 7'b1000000
	} fma_state_t;

	function automatic logic [52:0] unpack_mant(input logic [63:0] f);
		unpack_mant = {f[62:52] != 11'd0, f[51:0]};
	endfunction

	function automatic logic signed [13:0] unpack_exp(input logic [63:0] f);
		unpack_exp = (f[62:52] == 11'd0) ? -14'sd1074
			: $signed({3'b000, f[62:52]}) - 14'sd1075;
	endfunction

	fma_state_t state_q;
	logic [2:0] cnt_q;
	logic       done_q;

	logic [63:0]        result_q;
	logic [52:0]        ma_q;
	logic [52:0]        mb_q;
	logic [105:0]       acc_q;
	logic [105:0]       cm_q;
	logic [53:0]        pp_q;
	logic signed [13:0] ep_q;
	logic signed [13:0] ec_q;
	logic               sp_q;
	logic               sc_q;
	logic               czero_q;
	logic [216:0]       bw_q;
	logic [216:0]       sw_q;
	logic [216:0]       r_q;
	logic signed [13:0] te_q;
	logic               sign_q;
	logic               sub_q;

	// special operands
	logic        sp;
	logic        nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_a, zero_b, zero_c;
	logic        spec_hit;
	logic [63:0] spec_val;

	always_comb begin
		sp     = op_a[63] ^ op_b[63];
		nan_a  = op_a[62:0] > INF_ABS;
		nan_b  = op_b[62:0] > INF_ABS;
		nan_c  = op_c[62:0] > INF_ABS;
		inf_a  = op_a[62:0] == INF_ABS;
		inf_b  = op_b[62:0] == INF_ABS;
		inf_c  = op_c[62:0] == INF_ABS;
		zero_a = op_a[62:0] == 63'd0;
		zero_b = op_b[62:0] == 63'd0;
		zero_c = op_c[62:0] == 63'd0;
		spec_hit = 1'b1;
		priority if (nan_a) begin
			spec_val = op_a | QUIET_BIT;
		end else if (nan_b) begin
			spec_val = op_b | QUIET_BIT;
		end else if (nan_c) begin
			spec_val = op_c | QUIET_BIT;
		end else if ((inf_a && zero_b) || (inf_b && zero_a)) begin
			spec_val = DEFAULT_NAN;
		end else if (inf_a || inf_b) begin
			spec_val = (inf_c && op_c[63] != sp) ? DEFAULT_NAN : {sp, INF_ABS};
		end else if (inf_c) begin
			spec_val = op_c;
		end else if (zero_a || zero_b) begin
			spec_val = zero_c ? {sp & op_c[63], 63'd0} : op_c;
		end else begin
			spec_hit = 1'b0;
			spec_val = 64'd0;
		end
	end

	// multiply: partial products of 27-bit halves
	logic [26:0]  part_a;
	logic [26:0]  part_b;
	logic [1:0]   pi;
	logic [105:0] pp_ext;
	logic [105:0] pp_sh;

	always_comb begin
		part_a = cnt_q[0] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		part_b = cnt_q[1] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		pi     = 2'(cnt_q - 3'd1);
		pp_ext = {52'd0, pp_q};
		unique case (pi)
			2'd0:    pp_sh = pp_ext;
			2'd3:    pp_sh = pp_ext << 54;
			default: pp_sh = pp_ext << 27;
		endcase
	end

	logic p_done;
	logic c_done;
	assign p_done = acc_q[105];
	assign c_done = czero_q || cm_q[105];

	// alignment of the smaller operand under the larger one
	logic               p_big;
	logic [105:0]       big_m;
	logic [105:0]       small_m;
	logic signed [13:0] big_e;
	logic [14:0]        diff;
	logic [216:0]       sw_full;
	logic [216:0]       al;
	logic               al_st;

	always_comb begin
		p_big   = czero_q || (ep_q > ec_q) || (ep_q == ec_q && acc_q >= cm_q);
		big_m   = p_big ? acc_q : cm_q;
		small_m = czero_q ? 106'd0 : (p_big ? cm_q : acc_q);
		big_e   = p_big ? ep_q : ec_q;
		diff    = p_big ? 15'({ep_q[13], ep_q} - {ec_q[13], ec_q})
			: 15'({ec_q[13], ec_q} - {ep_q[13], ep_q});
		sw_full = {1'b0, small_m, 110'd0};
		if (diff >= 15'd217) begin
			al    = '0;
			al_st = |small_m;
		end else begin
			al    = sw_full >> diff;
			al_st = |(sw_full & ~({217{1'b1}} << diff));
		end
	end

	logic [216:0] r_sum;
	assign r_sum = sub_q ? bw_q - sw_q : bw_q + sw_q;

	// renormalize: left to the top bit, or right down to the subnormal range
	logic [13:0]        k_dn;
	logic [216:0]       fix_r;
	logic signed [13:0] fix_te;
	logic               fix_ready;

	always_comb begin
		k_dn      = 14'(EMIN - te_q);
		fix_r     = r_q;
		fix_te    = te_q;
		fix_ready = 1'b0;
		priority if (te_q < EMIN) begin
			fix_te = EMIN;
			if (k_dn >= 14'd217) begin
				fix_r = {216'd0, |r_q};
			end else begin
				fix_r    = r_q >> k_dn;
				fix_r[0] = fix_r[0] | (|(r_q & ~({217{1'b1}} << k_dn)));
			end
		end else if (!r_q[216] && te_q > EMIN) begin
			if (r_q[216:201] == 16'd0 && te_q >= EMIN + 14'sd16) begin
				fix_r  = r_q << 16;
				fix_te = te_q - 14'sd16;
			end else begin
				fix_r  = r_q << 1;
				fix_te = te_q - 14'sd1;
			end
		end else begin
			fix_ready = 1'b1;
		end
	end

	// rounding
	logic [53:0]        m_rnd;
	logic [52:0]        m_fin;
	logic signed [13:0] te_fin;
	logic signed [13:0] bexp;
	logic               rnd_up;
	logic [63:0]        round_val;

	always_comb begin
		rnd_up = r_q[163] && ((|r_q[162:0]) || r_q[164]);
		m_rnd  = {1'b0, r_q[216:164]} + {53'd0, rnd_up};
		if (m_rnd[53]) begin
			m_fin  = m_rnd[53:1];
			te_fin = te_q + 14'sd1;
		end else begin
			m_fin  = m_rnd[52:0];
			te_fin = te_q;
		end
		bexp = te_fin + 14'sd1023;
		priority if (!m_fin[52]) begin
			round_val = {sign_q, 11'd0, m_fin[51:0]};
		end else if (bexp >= 14'sd2047) begin
			round_val = {sign_q, INF_ABS};
		end else begin
			round_val = {sign_q, bexp[10:0], m_fin[51:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						if (spec_hit) begin
							done_q <= 1'b1;
						end else begin
							state_q <= F_MUL;
							cnt_q   <= '0;
						end
					end
				end
				F_MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= F_NORM;
					end
				end
				F_NORM: begin
					if (p_done && c_done) begin
						state_q <= F_ALIGN;
					end
				end
				F_ALIGN: state_q <= F_ADD;
				F_ADD: begin
					if (r_sum == '0) begin
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_FIX;
					end
				end
				F_FIX: begin
					if (fix_ready) begin
						state_q <= F_ROUND;
					end
				end
				F_ROUND: begin
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (start) begin
					result_q <= spec_val;
					ma_q     <= unpack_mant(op_a);
					mb_q     <= unpack_mant(op_b);
					cm_q     <= {unpack_mant(op_c), 53'd0};
					ep_q     <= unpack_exp(op_a) + unpack_exp(op_b);
					ec_q     <= unpack_exp(op_c) - 14'sd53;
					sp_q     <= sp;
					sc_q     <= op_c[63];
					czero_q  <= zero_c;
					acc_q    <= '0;
				end
			end
			F_MUL: begin
				pp_q <= {27'd0, part_a} * {27'd0, part_b};
				if (cnt_q != 3'd0) begin
					acc_q <= acc_q + pp_sh;
				end
			end
			F_NORM: begin
				if (!p_done) begin
					if (acc_q[105:90] == 16'd0) begin
						acc_q <= acc_q << 16;
						ep_q  <= ep_q - 14'sd16;
					end else begin
						acc_q <= acc_q << 1;
						ep_q  <= ep_q - 14'sd1;
					end
				end
				if (!c_done) begin
					if (cm_q[105:90] == 16'd0) begin
						cm_q <= cm_q << 16;
						ec_q <= ec_q - 14'sd16;
					end else begin
						cm_q <= cm_q << 1;
						ec_q <= ec_q - 14'sd1;
					end
				end
			end
			F_ALIGN: begin
				bw_q   <= {1'b0, big_m, 110'd0};
				sw_q   <= {al[216:1], al[0] | al_st};
				te_q   <= big_e + 14'sd106;
				sign_q <= p_big ? sp_q : sc_q;
				sub_q  <= !czero_q && (sp_q != sc_q);
			end
			F_ADD: begin
				r_q      <= r_sum;
				result_q <= 64'd0;
			end
			F_FIX: begin
				r_q  <= fix_r;
				te_q <= fix_te;
			end
			F_ROUND: result_q <= round_val;
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: design/srgd_back.sv
// Back end: pops ops, runs lane FMAs, the lane combine and tail
// multiply/add on the shared FMA unit, and holds the result register.
// Depends on srgd_pkg and srgd_fma.
module srgd_back import srgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         head,
	input  fifo_stat_t  q_stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] row_sum
);

	typedef enum logic [7:0] {
		B_FETCH  = 8'b00000001,
		B_LANE   = 8'b00000010,
		B_SUM01  = 8'b00000100,
		B_SUM23  = 8'b00001000,
		B_SUMALL = 8'b00010000,
		B_TMUL   = 8'b00100000,
		B_TADD   = 8'b01000000,
		B_EMIT   = 8'b10000000
	} back_state_t;

	back_state_t state_q;
	logic        busy_q;
	logic        out_valid_q;
	logic [63:0] row_sum_q;
	op_t         cur_q;
	logic [63:0] lanes_q [LANES];
	logic [63:0] tail_q;
	logic [63:0] s01_q;
	logic [63:0] prod_q;

	logic        fma_state;
	logic        fma_start;
	logic        fma_done;
	logic [63:0] fma_res;
	logic [63:0] fa, fb, fc;
	logic        emit_load;

	always_comb begin
		fma_state = 1'b1;
		unique case (state_q)
			B_LANE: begin
				fa = cur_q.val; fb = cur_q.x; fc = lanes_q[cur_q.lane];
			end
			B_SUM01: begin
				fa = ONE_BITS; fb = lanes_q[0]; fc = lanes_q[1];
			end
			B_SUM23: begin
				fa = ONE_BITS; fb = lanes_q[2]; fc = lanes_q[3];
			end
			B_SUMALL: begin
				fa = ONE_BITS; fb = s01_q; fc = prod_q;
			end
			B_TMUL: begin
				fa = cur_q.val; fb = cur_q.x; fc = NEG_ZERO;
			end
			B_TADD: begin
				fa = ONE_BITS; fb = tail_q; fc = prod_q;
			end
			default: begin
				fma_state = 1'b0;
				fa = ONE_BITS; fb = tail_q; fc = prod_q;
			end
		endcase
	end

	assign fma_start = fma_state && !busy_q;
	assign pop       = (state_q == B_FETCH) && !q_stat.empty;
	assign emit_load = (state_q == B_EMIT) && (!out_valid_q || !out_stall);

	srgd_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fma_start),
		.op_a   (fa),
		.op_b   (fb),
		.op_c   (fc),
		.done   (fma_done),
		.result (fma_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_FETCH;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit_load || (out_valid_q && out_stall);
			if (fma_start) begin
				busy_q <= 1'b1;
			end else if (fma_done) begin
				busy_q <= 1'b0;
			end
			unique case (state_q)
				B_FETCH: begin
					if (pop) begin
						unique case (head.op)
							OP_EMPTY: state_q <= B_EMIT;
							OP_LANE:  state_q <= B_LANE;
							OP_TAIL:  state_q <= B_TMUL;
							default:  state_q <= B_FETCH;
						endcase
					end
				end
				B_LANE: begin
					if (fma_done) begin
						state_q <= cur_q.combine ? B_SUM01 : B_FETCH;
					end
				end
				B_SUM01: begin
					if (fma_done) begin
						state_q <= B_SUM23;
					end
				end
				B_SUM23: begin
					if (fma_done) begin
						state_q <= B_SUMALL;
					end
				end
				B_SUMALL, B_TADD: begin
					if (fma_done) begin
						state_q <= cur_q.last ? B_EMIT : B_FETCH;
					end
				end
				B_TMUL: begin
					if (fma_done) begin
						state_q <= B_TADD;
					end
				end
				B_EMIT: begin
					if (emit_load) begin
						state_q <= B_FETCH;
					end
				end
				default: state_q <= B_FETCH;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
			// a new row, empty or not, starts from positive zero
			if (head.op == OP_START || head.op == OP_EMPTY) begin
				for (int i = 0; i < LANES; i++) begin
					lanes_q[i] <= 64'd0;
				end
				tail_q <= 64'd0;
			end
		end
		if (fma_done) begin
			unique case (state_q)
				B_LANE:           lanes_q[cur_q.lane] <= fma_res;
				B_SUM01:          s01_q <= fma_res;
				B_SUM23, B_TMUL:  prod_q <= fma_res;
				B_SUMALL, B_TADD: tail_q <= fma_res;
				default: begin
				end
			endcase
		end
		if (emit_load) begin
			row_sum_q <= tail_q;
		end
	end

	assign out_valid = out_valid_q;
	assign row_sum   = row_sum_q;

endmodule

// File: design/sparse_row_gather_dot_product_top.sv
// Sparse row gather dot product: dense binary64 vector memory plus a
// row engine that accumulates gathered products. Uses srgd_pkg,
// srgd_front, srgd_queue and srgd_back.
//
// Vector writes go into a 4096-entry memory at one item per cycle while
// in_stall is low. Start and element items become ops in a four-entry queue,
// so the input keeps flowing while the back end works. Element ops run on one
// shared iterative FMA unit. A lane element costs one pass, a tail element
// two, and the element that closes the last full group of four adds three
// passes for the lane combine. An empty row gives +0.0 without an FMA pass.
// Results wait in an output register, and the back end keeps working on
// later ops until it has the next result ready.
module sparse_row_gather_dot_product_top import srgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [11:0] position,
	input  logic [63:0] value,
	input  logic [15:0] row_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] row_sum
);

	logic       push;
	op_t        push_data;
	logic       pop;
	op_t        head;
	fifo_stat_t q_stat;

	srgd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.row_length (row_length),
		.push       (push),
		.push_data  (push_data),
		.q_stat     (q_stat)
	);

	srgd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	srgd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.row_sum   (row_sum)
	);

endmodule

// File: design/srgd_checker.sv
// Port-level checks for the sparse row gather dot product top level,
// attached by bind. Depends only on the top level's ports.
module srgd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  kind,
	input logic [11:0] position,
	input logic [63:0] value,
	input logic [15:0] row_length,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] row_sum
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_sum))
		else $error("row_sum changed while stalled");

	// a result leaves only when taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped without handshake");

	// reset empties both the queue and the output register
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("state not cleared in reset");

	// queue back-pressure only builds up behind an accepted item
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall rose without an accepted item");

endmodule

bind sparse_row_gather_dot_product_top srgd_checker u_srgd_checker (.*);

// File: sim/sparse_row_gather_dot_product_top_test.sv
// Testbench for sparse_row_gather_dot_product_top: directed and random rows with
// a bit-exact binary64 fused multiply-add predictor and randomized backpressure.
// Depends on srgd_pkg and the RTL of the block only.
module sparse_row_gather_dot_product_top_test import srgd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  KIND_UNUSED = 2'd3;
	localparam logic [63:0] POS_INF     = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] NEG_INF     = 64'hFFF0_0000_0000_0000;
	localparam logic [63:0] SIG_NAN     = 64'h7FF0_0000_0000_0001;
	localparam logic [63:0] HUGE_VAL    = 64'h7FEF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN_SUB     = 64'h0000_0000_0000_0001;
	localparam int          CYCLE_LIMIT = 600000;
	localparam int          HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [11:0] position;
	logic [63:0] value;
	logic [15:0] row_length;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] row_sum;

	sparse_row_gather_dot_product_top DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .position(position), .value(value), .row_length(row_length),
		.out_valid(out_valid), .out_stall(out_stall), .row_sum(row_sum)
	);

	// predictor state
	logic [63:0] vec_mem [VECTOR_DEPTH];
	bit          vec_written [VECTOR_DEPTH];
	int          written_addrs [$];
	logic [63:0] lane_acc [LANES];
	logic [63:0] tail_acc;
	int          seen_count;
	int          row_len_cur;
	bit          row_is_open;

	logic [63:0] expected_sums [$];
	int          error_count;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_req;
	bit          hold_taken = 1'b0;
	int          hold_left = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int bit_len(logic [191:0] w);
		for (int i = 191; i >= 0; i--)
			if (w[i]) return i + 1;
		return 0;
	endfunction

	// move onto the 192-bit working grid, keeping a sticky bit on right shifts
	function automatic logic [191:0] align(logic [191:0] w, int s);
		logic [191:0] r;
		logic         st;
		if (s >= 0) return w << s;
		if (-s >= 192) return {191'b0, |w};
		st = |(w & ((192'b1 << (-s)) - 1));
		r = w >> (-s);
		r[0] = r[0] | st;
		return r;
	endfunction

	// round(a*b + c) once, nearest even
	function automatic logic [63:0] fused_madd(logic [63:0] a, logic [63:0] b, logic [63:0] c);
		logic         sp, sc, sgn, rnd, st;
		logic [52:0]  ma, mb, mc;
		int           ea, eb, ec, t_top, h, lsb, sh;
		logic [191:0] p, cc, r, prod;
		logic [63:0]  m;
		bit           ainf, binf, cinf, az, bz, cz;
		sp = a[63] ^ b[63];
		sc = c[63];
		if (a[62:0] > INF_ABS) return a | QUIET_BIT;
		if (b[62:0] > INF_ABS) return b | QUIET_BIT;
		if (c[62:0] > INF_ABS) return c | QUIET_BIT;
		ainf = a[62:0] == INF_ABS; binf = b[62:0] == INF_ABS; cinf = c[62:0] == INF_ABS;
		az = a[62:0] == 0; bz = b[62:0] == 0; cz = c[62:0] == 0;
		if ((ainf && bz) || (binf && az)) return DEFAULT_NAN;
		if (ainf || binf) begin
			if (cinf && sc != sp) return DEFAULT_NAN;
			return {sp, INF_ABS};
		end
		if (cinf) return c;
		if (az || bz) return cz ? {sp & sc, 63'b0} : c;
		ma = {a[62:52] != 0, a[51:0]}; ea = (a[62:52] == 0) ? -1074 : int'(a[62:52]) - 1075;
		mb = {b[62:52] != 0, b[51:0]}; eb = (b[62:52] == 0) ? -1074 : int'(b[62:52]) - 1075;
		mc = {c[62:52] != 0, c[51:0]}; ec = (c[62:52] == 0) ? -1074 : int'(c[62:52]) - 1075;
		prod = 192'(ma) * 192'(mb);
		t_top = ea + eb + bit_len(prod);
		if (!cz && ec + bit_len(192'(mc)) > t_top) t_top = ec + bit_len(192'(mc));
		p = align(prod, ea + eb - (t_top - 190));
		cc = cz ? 192'b0 : align(192'(mc), ec - (t_top - 190));
		if (cz || sp == sc) begin
			r = p + cc;
			sgn = sp;
		end else begin
			if (p == cc) return 64'b0;
			if (p > cc) begin
				r = p - cc; sgn = sp;
			end else begin
				r = cc - p; sgn = sc;
			end
		end
		if (r == 0) return 64'b0;
		h = bit_len(r) - 1;
		lsb = h + t_top - 190 - 52;
		if (lsb < -1074) lsb = -1074;
		sh = lsb - (t_top - 190);
		if (sh <= 0) begin
			m = 64'(r << (-sh));
		end else if (sh > 192) begin
			m = 64'b0;
		end else begin
			rnd = r[sh-1];
			st = (sh > 1) && |(r & ((192'b1 << (sh - 1)) - 1));
			m = 64'(r >> sh);
			if (rnd && (st || m[0])) m++;
		end
		if (m >= 64'h0020_0000_0000_0000) begin
			m = m >> 1; lsb++;
		end
		if (m < 64'h0010_0000_0000_0000) return {sgn, m[62:0]};
		if (lsb + 1075 >= 2047) return {sgn, INF_ABS};
		return {sgn, 11'(lsb + 1075), m[51:0]};
	endfunction

	task automatic predict_item(logic [1:0] k, logic [11:0] pos, logic [63:0] val,
		logic [15:0] len);
		logic [63:0] x;
		int          full, j;
		case (k)
			KIND_WRITE: vec_mem[pos] = val;
			KIND_START: begin
				for (int i = 0; i < LANES; i++) lane_acc[i] = 64'b0;
				tail_acc = 64'b0;
				seen_count = 0;
				row_len_cur = (len > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : len;
				row_is_open = row_len_cur != 0;
				if (row_len_cur == 0) expected_sums.push_back(64'b0);
			end
			KIND_ELEM: if (row_is_open) begin
				x = vec_mem[pos];
				full = row_len_cur - row_len_cur % LANES;
				j = seen_count;
				if (j < full) begin
					lane_acc[j % LANES] = fused_madd(val, x, lane_acc[j % LANES]);
					if (j + 1 == full)
						tail_acc = fused_madd(ONE_BITS,
							fused_madd(ONE_BITS, lane_acc[0], lane_acc[1]),
							fused_madd(ONE_BITS, lane_acc[2], lane_acc[3]));
				end else begin
					tail_acc = fused_madd(ONE_BITS, tail_acc, fused_madd(val, x, NEG_ZERO));
				end
				seen_count = j + 1;
				if (seen_count >= row_len_cur) begin
					row_is_open = 0;
					expected_sums.push_back(tail_acc);
				end
			end
			default: ;
		endcase
	endtask

	// called at a falling edge; leaves in_valid high after acceptance
	task automatic send_item(logic [1:0] k, logic [11:0] pos, logic [63:0] val,
		logic [15:0] len);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		kind <= k; position <= pos; value <= val; row_length <= len;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_item(k, pos, val, len);
		@(negedge clk);
	endtask

	task automatic write_vec(logic [11:0] pos, logic [63:0] val);
		if (!vec_written[pos]) begin
			vec_written[pos] = 1;
			written_addrs.push_back(pos);
		end
		send_item(KIND_WRITE, pos, val, 16'd0);
	endtask

	function automatic logic [11:0] any_written();
		return 12'(written_addrs[$urandom_range(written_addrs.size() - 1)]);
	endfunction

	// matrix values mostly stay near one so that products with subnormals stay in range
	function automatic logic [63:0] rand_matrix_val();
		int sel;
		sel = $urandom_range(99);
		if (sel < 85)
			return {1'($urandom), 11'($urandom_range(1033, 1013)), $urandom, 20'($urandom)};
		case (sel % 5)
			0: return {1'($urandom), 63'b0};
			1: return {1'($urandom), INF_ABS};
			2: return {1'($urandom), HUGE_VAL[62:0]};
			3: return {1'($urandom), 12'hFFF, 19'($urandom), $urandom} | 64'h7FF0_0000_0000_0001;
			default: return {1'($urandom), 11'($urandom_range(1100, 950)), $urandom, 20'($urandom)};
		endcase
	endfunction

	function automatic logic [63:0] rand_vector_val();
		int sel;
		sel = $urandom_range(99);
		if (sel < 75)
			return {1'($urandom), 11'($urandom_range(1043, 1003)), $urandom, 20'($urandom)};
		case (sel % 6)
			0: return {1'($urandom), 63'b0};
			1: return {1'($urandom), 12'h001, 19'($urandom), $urandom};
			2: return {1'($urandom), INF_ABS};
			3: return {1'($urandom), 11'h7FF, 1'b1, 19'($urandom), $urandom};
			4: return {$urandom, $urandom};
			default: return {1'($urandom), HUGE_VAL[62:0]};
		endcase
	endfunction

	task automatic send_row(int len);
		send_item(KIND_START, 12'($urandom), rand_matrix_val(), 16'(len));
		for (int i = 0; i < len; i++)
			send_item(KIND_ELEM, any_written(), rand_matrix_val(), 16'($urandom));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		wait (expected_sums.size() == 0);
		repeat (150) @(negedge clk);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		error_count++;
		if (error_count <= 40)
			$display("%0t: %s: row_sum got %h expected %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_sums.size() == 0)
				report_mismatch("unexpected row", row_sum, 64'bx);
			else if (row_sum !== expected_sums[0]) begin
				report_mismatch("wrong row sum", row_sum, expected_sums[0]);
				void'(expected_sums.pop_front());
			end else
				void'(expected_sums.pop_front());
		end
	end

	// receiver: one long hold on request, random idling otherwise
	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES - 1;
			out_stall  <= 1'b1;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else
			out_stall <= $urandom_range(99) < recv_idle_pct;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic test_vector_load();
		write_vec(12'd0, ONE_BITS);
		write_vec(12'd4095, rand_vector_val());
		write_vec(12'd1, SIG_NAN);
		write_vec(12'd2, 64'b0);
		write_vec(12'd3, 64'hC004_0000_0000_0000);
		write_vec(12'd5, 64'h000F_FFFF_0000_0001);
		write_vec(12'd6, HUGE_VAL);
		for (int i = 0; i < 60; i++)
			write_vec(12'($urandom), rand_vector_val());
		wait_drained();
	endtask

	task automatic test_special_rows();
		send_item(KIND_START, 12'd0, 64'b0, 16'd0);          // empty row
		send_item(KIND_ELEM, 12'd0, ONE_BITS, 16'd0);        // no open row
		send_item(KIND_UNUSED, 12'hFFF, {64{1'b1}}, 16'hFFFF);
		send_item(KIND_START, 12'd0, 64'b0, 16'd1);
		send_item(KIND_ELEM, 12'd4095, 64'hBFF8_0000_0000_0000, 16'd0);
		send_item(KIND_START, 12'd0, 64'b0, 16'd4);           // one full group
		for (int i = 0; i < 4; i++)
			send_item(KIND_ELEM, any_written(), rand_matrix_val(), 16'd0);
		send_item(KIND_START, 12'd0, 64'b0, 16'd5);           // group and tail
		send_item(KIND_ELEM, 12'd3, ONE_BITS, 16'd0);
		send_item(KIND_ELEM, 12'd5, HUGE_VAL, 16'd0);
		send_item(KIND_ELEM, 12'd6, HUGE_VAL, 16'd0);
		send_item(KIND_ELEM, 12'd0, MIN_SUB, 16'd0);
		send_item(KIND_ELEM, 12'd5, 64'h8000_0000_0000_0000, 16'd0);
		send_item(KIND_START, 12'd0, 64'b0, 16'hFFFF);        // dropped by next start
		send_item(KIND_ELEM, 12'd0, ONE_BITS, 16'd0);
		send_item(KIND_START, 12'd0, 64'b0, 16'd3);
		send_item(KIND_ELEM, 12'd1, ONE_BITS, 16'd0);         // NaN entry
		send_item(KIND_ELEM, 12'd2, POS_INF, 16'd0);          // inf times zero
		send_item(KIND_ELEM, 12'd0, ONE_BITS, 16'd0);
		send_item(KIND_START, 12'd0, 64'b0, 16'd2);           // inf minus inf
		send_item(KIND_ELEM, 12'd0, POS_INF, 16'd0);
		send_item(KIND_ELEM, 12'd0, NEG_INF, 16'd0);
		send_item(KIND_START, 12'd0, 64'b0, 16'd1);           // negative zero product
		send_item(KIND_ELEM, 12'd2, 64'hBFF0_0000_0000_0000, 16'd0);
		wait_drained();
	endtask

	task automatic test_random_rows(int items, int s_pct, int r_pct);
		int sent, sel, len;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		sent = 0;
		while (sent < items) begin
			sel = $urandom_range(99);
			if (sel < 8) begin
				write_vec(12'($urandom), rand_vector_val());
				sent++;
			end else if (sel < 12) begin
				if (row_is_open || sel == 8)
					send_item(KIND_UNUSED, 12'($urandom), {$urandom, $urandom}, 16'($urandom));
				else
					send_item(KIND_ELEM, any_written(), rand_matrix_val(), 16'($urandom));
				sent++;
			end else if (sel < 16) begin
				len = $urandom_range(12, 3);
				send_item(KIND_START, 12'($urandom), 64'b0, 16'(len));
				for (int i = 0; i < len / 2; i++)
					send_item(KIND_ELEM, any_written(), rand_matrix_val(), 16'd0);
				sent += 1 + len / 2;
			end else begin
				len = (sel < 22) ? $urandom_range(17, 12) : $urandom_range(9, 0);
				send_row(len);
				sent += len + 1;
			end
		end
		// close any broken row so later phases start clean
		send_item(KIND_START, 12'd0, 64'b0, 16'd0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk);
		hold_req = 1'b1;
		for (int i = 0; i < 6; i++)
			send_row(4);
		send_row(5);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_WRITE;
		position = '0;
		value = '0;
		row_length = '0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		error_count = 0;
		cycle_count = 0;
		row_is_open = 0;
		seen_count = 0;
		row_len_cur = 0;
		tail_acc = '0;
		for (int i = 0; i < VECTOR_DEPTH; i++) begin
			vec_mem[i] = '0;
			vec_written[i] = 0;
		end
		for (int i = 0; i < LANES; i++) lane_acc[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_vector_load();
		test_special_rows();
		test_random_rows(90, 15, 82);
		test_random_rows(90, 82, 15);
		test_random_rows(90, 0, 0);
		test_backpressure();

		if (error_count == 0 && expected_sums.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
